FILE: hdl/detect_anchor_box_decode_assert.svh
// Assertion macros shared by the anchor box decoder RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef DETECT_ANCHOR_BOX_DECODE_ASSERT_SVH
`define DETECT_ANCHOR_BOX_DECODE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define DABD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DABD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dabd_pkg.sv
// Package for the anchor box decoder: register map, reset values, fixed widths.
// No dependencies.
package dabd_pkg;

    // Fixed field widths
    localparam int THR_W    = 9;
    localparam int RATIO_W  = 16;
    localparam int PIX_W    = 14;
    localparam int NCLS_W   = 8;
    localparam int LABEL_W  = 7;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Fixed point: corners in Q.21 after scaling
    localparam int FRAC_SHIFT = 21;
    localparam int CORNER_W   = PIX_W + FRAC_SHIFT;

    // Register reset values
    localparam logic [THR_W-1:0]   THRESHOLD_RST  = 9'd64;
    localparam logic [RATIO_W-1:0] RATIO_RST      = 16'd4096;
    localparam logic [PIX_W-1:0]   IMG_WIDTH_RST  = 14'd640;
    localparam logic [PIX_W-1:0]   IMG_HEIGHT_RST = 14'd640;
    localparam logic [NCLS_W-1:0]  NUM_CLASS_RST  = 8'd80;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_RATIO       = 3'd1,
        CFG_IMG_WIDTH   = 3'd2,
        CFG_IMG_HEIGHT  = 3'd3,
        CFG_NUM_CLASSES = 3'd4
    } cfg_reg_t;

    // Geometry settings handed to the box pipeline
    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [PIX_W-1:0]   width;
        logic [PIX_W-1:0]   height;
    } geom_cfg_t;

endpackage

FILE: hdl/dabd_value_if.sv
// Valid/ready channel carrying one signed element of an anchor row.
// Depends on nothing.
interface dabd_value_if #(parameter int VALUE_WIDTH = 20);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: hdl/dabd_result_if.sv
// Valid/ready channel carrying one detection: label, score and box.
// Depends on dabd_pkg for the fixed field widths.
interface dabd_result_if #(parameter int VALUE_WIDTH = 20);
    logic                             valid;
    logic                             ready;
    logic [dabd_pkg::LABEL_W-1:0]     label;
    logic signed [VALUE_WIDTH-1:0]    score;
    logic [dabd_pkg::PIX_W-1:0]       box_x;
    logic [dabd_pkg::PIX_W-1:0]       box_y;
    logic [dabd_pkg::PIX_W-1:0]       box_width;
    logic [dabd_pkg::PIX_W-1:0]       box_height;

    modport source (output valid, output label, output score, output box_x,
                    output box_y, output box_width, output box_height, input ready);
    modport sink   (input valid, input label, input score, input box_x,
                    input box_y, input box_width, input box_height, output ready);
endinterface

FILE: hdl/dabd_box_pipe.sv
// Box mapping pipeline: corner sums, scaling multiply, clamp, then width/height
// and rounding into the output register. Depends on dabd_pkg and dabd_result_if.
module dabd_box_pipe #(
    parameter int VALUE_WIDTH = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dabd_pkg::geom_cfg_t              geom,
    input  logic                             load,
    output logic                             load_ready,
    input  logic [dabd_pkg::LABEL_W-1:0]     load_label,
    input  logic signed [VALUE_WIDTH-1:0]    load_score,
    input  logic signed [VALUE_WIDTH-1:0]    centre_x,
    input  logic signed [VALUE_WIDTH-1:0]    centre_y,
    input  logic signed [VALUE_WIDTH-1:0]    size_w,
    input  logic signed [VALUE_WIDTH-1:0]    size_h,
    dabd_result_if.source                    det
);

    localparam int TW = VALUE_WIDTH + 2;                 // 2*c +/- s
    localparam int PW = TW + dabd_pkg::RATIO_W + 1;      // scaled corner
    localparam int CW = dabd_pkg::CORNER_W;              // clamped corner
    localparam int XW = (PW > CW + 1) ? PW : CW + 1;     // clamp compare width
    localparam int LW = dabd_pkg::LABEL_W;
    localparam int PX = dabd_pkg::PIX_W;
    localparam int FS = dabd_pkg::FRAC_SHIFT;

    // Corner clamped to [0, lim << 21]
    function automatic logic [CW-1:0] clamp_corner(input logic signed [PW-1:0] p,
                                                   input logic [PX-1:0] lim);
        logic signed [XW-1:0] pe;
        logic signed [XW-1:0] top;
        logic [CW-1:0]        r;
        pe  = p;
        top = $signed({{(XW-CW){1'b0}}, lim, {FS{1'b0}}});
        if (pe < 0)
            r = '0;
        else if (pe > top)
            r = top[CW-1:0];
        else
            r = pe[CW-1:0];
        return r;
    endfunction

    // Round half up to whole pixels, low pixel bits kept
    function automatic logic [PX-1:0] round_px(input logic [CW-1:0] v);
        logic [CW:0] s;
        s = {1'b0, v} + (CW+1)'(1 << (FS - 1));
        return s[CW-1:FS];
    endfunction

    // Stage handshake
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready;

    assign d_ready    = !d_valid_reg || det.ready;
    assign c_ready    = !c_valid_reg || d_ready;
    assign b_ready    = !b_valid_reg || c_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign load_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg <= load;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
            if (d_ready) d_valid_reg <= c_valid_reg;
        end
    end

    // Stage A: twice-centre minus/plus size
    logic [LW-1:0]        a_label_reg, b_label_reg, c_label_reg, d_label_reg;
    logic signed [VALUE_WIDTH-1:0] a_score_reg, b_score_reg, c_score_reg, d_score_reg;
    logic signed [TW-1:0] a_x0_reg, a_x1_reg, a_y0_reg, a_y1_reg;
    logic signed [TW-1:0] cx2, cy2, sw, sh;

    assign cx2 = $signed({centre_x[VALUE_WIDTH-1], centre_x, 1'b0});
    assign cy2 = $signed({centre_y[VALUE_WIDTH-1], centre_y, 1'b0});
    assign sw  = $signed({{2{size_w[VALUE_WIDTH-1]}}, size_w});
    assign sh  = $signed({{2{size_h[VALUE_WIDTH-1]}}, size_h});

    always_ff @(posedge clk)
    begin
        if (a_ready && load)
        begin
            a_label_reg <= load_label;
            a_score_reg <= load_score;
            a_x0_reg    <= cx2 - sw;
            a_x1_reg    <= cx2 + sw;
            a_y0_reg    <= cy2 - sh;
            a_y1_reg    <= cy2 + sh;
        end
    end

    // Stage B: scale by ratio
    localparam int RATIO_W_S = dabd_pkg::RATIO_W + 1;
    logic signed [RATIO_W_S-1:0] ratio_s;
    logic signed [PW-1:0] b_x0_reg, b_x1_reg, b_y0_reg, b_y1_reg;

    assign ratio_s = $signed({1'b0, geom.ratio});

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_label_reg <= a_label_reg;
            b_score_reg <= a_score_reg;
            b_x0_reg    <= a_x0_reg * ratio_s;
            b_x1_reg    <= a_x1_reg * ratio_s;
            b_y0_reg    <= a_y0_reg * ratio_s;
            b_y1_reg    <= a_y1_reg * ratio_s;
        end
    end

    // Stage C: clamp corners to the image
    logic [CW-1:0] c_x0_reg, c_x1_reg, c_y0_reg, c_y1_reg;

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_label_reg <= b_label_reg;
            c_score_reg <= b_score_reg;
            c_x0_reg    <= clamp_corner(b_x0_reg, geom.width);
            c_x1_reg    <= clamp_corner(b_x1_reg, geom.width);
            c_y0_reg    <= clamp_corner(b_y0_reg, geom.height);
            c_y1_reg    <= clamp_corner(b_y1_reg, geom.height);
        end
    end

    // Stage D: extents and rounding into the output register
    logic [CW-1:0] dx, dy;
    logic [PX-1:0] d_x_reg, d_y_reg, d_w_reg, d_h_reg;

    assign dx = (c_x1_reg >= c_x0_reg) ? c_x1_reg - c_x0_reg : '0;
    assign dy = (c_y1_reg >= c_y0_reg) ? c_y1_reg - c_y0_reg : '0;

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_label_reg <= c_label_reg;
            d_score_reg <= c_score_reg;
            d_x_reg     <= round_px(c_x0_reg);
            d_y_reg     <= round_px(c_y0_reg);
            d_w_reg     <= round_px(dx);
            d_h_reg     <= round_px(dy);
        end
    end

    assign det.valid      = d_valid_reg;
    assign det.label      = d_label_reg;
    assign det.score      = d_score_reg;
    assign det.box_x      = d_x_reg;
    assign det.box_y      = d_y_reg;
    assign det.box_width  = d_w_reg;
    assign det.box_height = d_h_reg;

endmodule

FILE: hdl/detect_anchor_box_decode.sv
// Anchor row decoder top level: register port, running argmax, box pipeline.
// Depends on dabd_pkg, dabd_value_if, dabd_result_if, dabd_box_pipe and the
// assertion header.
//
// Usage: an anchor row streams in on row, one element per item: centre x,
// centre y, width, height, then num_classes scores (Q12.8). The first highest
// score wins. If it is strictly above the threshold, one item leaves on det
// with label, score and the box in image pixels; otherwise the row gives none.
// Throughput: one element per cycle while row.ready is high; the argmax compare is combinational.
// Path: the corner sums are registered at the edge that accepted the last
// score, then the multiply, clamp and round/output stages follow before the
// detection is shown on det.
// Stall: a four-deep register pipeline holds detections while det is stalled;
// row.ready falls only when the first stage is full and cannot move on.
// Reset: registers take their defaults, the row restarts at centre x and all
// pipeline stages empty. Registers are written over APB with pready tied high.
// The user must write them only while no row is in progress; it is not enforced.
`include "detect_anchor_box_decode_assert.svh"

module detect_anchor_box_decode #(
    parameter int MAX_CLASSES = 128,
    parameter int VALUE_WIDTH = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dabd_pkg::PADDR_W-1:0]     paddr,
    input  logic [dabd_pkg::PDATA_W-1:0]     pwdata,
    output logic [dabd_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    dabd_value_if.sink                       row,
    dabd_result_if.source                    det
);

    localparam int IDX_W = $clog2(MAX_CLASSES + 4);
    localparam int THR_W = dabd_pkg::THR_W;

    // Configuration registers
    logic [THR_W-1:0]                threshold_reg;
    logic [dabd_pkg::RATIO_W-1:0]    ratio_reg;
    logic [dabd_pkg::PIX_W-1:0]      image_width_reg;
    logic [dabd_pkg::PIX_W-1:0]      image_height_reg;
    logic [dabd_pkg::NCLS_W-1:0]     num_classes_reg;
    logic                            wr_en;
    dabd_pkg::cfg_reg_t              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = dabd_pkg::cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= dabd_pkg::THRESHOLD_RST;
            ratio_reg        <= dabd_pkg::RATIO_RST;
            image_width_reg  <= dabd_pkg::IMG_WIDTH_RST;
            image_height_reg <= dabd_pkg::IMG_HEIGHT_RST;
            num_classes_reg  <= dabd_pkg::NUM_CLASS_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                dabd_pkg::CFG_THRESHOLD:   threshold_reg    <= pwdata[THR_W-1:0];
                dabd_pkg::CFG_RATIO:       ratio_reg        <= pwdata[dabd_pkg::RATIO_W-1:0];
                dabd_pkg::CFG_IMG_WIDTH:   image_width_reg  <= pwdata[dabd_pkg::PIX_W-1:0];
                dabd_pkg::CFG_IMG_HEIGHT:  image_height_reg <= pwdata[dabd_pkg::PIX_W-1:0];
                dabd_pkg::CFG_NUM_CLASSES: num_classes_reg  <= pwdata[dabd_pkg::NCLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (reg_sel)
            dabd_pkg::CFG_THRESHOLD:   prdata = 32'(threshold_reg);
            dabd_pkg::CFG_RATIO:       prdata = 32'(ratio_reg);
            dabd_pkg::CFG_IMG_WIDTH:   prdata = 32'(image_width_reg);
            dabd_pkg::CFG_IMG_HEIGHT:  prdata = 32'(image_height_reg);
            dabd_pkg::CFG_NUM_CLASSES: prdata = 32'(num_classes_reg);
            default:                   prdata = '0;
        endcase
    end

    // Effective class count: zero counts as one, saturate at MAX_CLASSES
    logic [IDX_W-1:0] n_eff, last_idx;

    always_comb
    begin
        if (num_classes_reg == '0)
            n_eff = IDX_W'(1);
        else if (32'(num_classes_reg) > MAX_CLASSES)
            n_eff = IDX_W'(MAX_CLASSES);
        else
            n_eff = IDX_W'(num_classes_reg);
        last_idx = n_eff + IDX_W'(3);
    end

    // Row state
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic signed [VALUE_WIDTH-1:0] best_score_reg, best_score_next;
    logic [IDX_W-1:0]              best_label_reg, best_label_next;
    logic signed [VALUE_WIDTH-1:0] box_reg [4];
    logic                          fire, in_box, row_end, take, emit, pipe_ready;
    logic                          row_done, box_inside;
    logic signed [THR_W:0]         thr_s;

    assign fire     = row.valid && row.ready;
    assign in_box   = idx_reg < IDX_W'(4);
    assign row_end  = !(idx_reg < last_idx);
    assign row_done = fire && !in_box && row_end;
    assign take     = (idx_reg == IDX_W'(4)) || (row.value > best_score_reg);
    assign thr_s    = $signed({1'b0, threshold_reg});

    // Running argmax, first maximum kept
    always_comb
    begin
        best_score_next = best_score_reg;
        best_label_next = best_label_reg;
        if (!in_box && take)
        begin
            best_score_next = row.value;
            best_label_next = idx_reg - IDX_W'(4);
        end
        idx_next = row_end ? '0 : idx_reg + IDX_W'(1);
    end

    assign emit      = row_done && (best_score_next > thr_s);
    assign row.ready = pipe_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            best_score_reg <= '0;
            best_label_reg <= '0;
        end
        else if (fire)
        begin
            idx_reg        <= idx_next;
            best_score_reg <= best_score_next;
            best_label_reg <= best_label_next;
        end
    end

    // Box elements of the current row
    always_ff @(posedge clk)
    begin
        if (fire && in_box)
            box_reg[idx_reg[1:0]] <= row.value;
    end

    // Box mapping pipeline
    dabd_pkg::geom_cfg_t geom;

    assign geom.ratio  = ratio_reg;
    assign geom.width  = image_width_reg;
    assign geom.height = image_height_reg;

    dabd_box_pipe #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_box_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .load       (emit),
        .load_ready (pipe_ready),
        .load_label (dabd_pkg::LABEL_W'(best_label_next)),
        .load_score (best_score_next),
        .centre_x   (box_reg[0]),
        .centre_y   (box_reg[1]),
        .size_w     (box_reg[2]),
        .size_h     (box_reg[3]),
        .det        (det)
    );

    // Checks
    assign box_inside = (det.box_x <= image_width_reg) && (det.box_y <= image_height_reg);

    `DABD_ASSERT_SAME(a_det_above_thr, det.valid, det.score > thr_s, "score not above threshold")
    `DABD_ASSERT_SAME(a_box_in_image, det.valid, box_inside, "box origin outside image")
    `DABD_ASSERT_NEXT(a_row_restart, row_done, idx_reg == '0, "row did not restart")

endmodule
